FILE: hw/rtl/apct_pkg.sv
// package for the aabb pair collision table: sizes, codes, entry and result types
`timescale 1ns / 1ps
`default_nettype none

package apct_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int NUM_TYPES = 32;

    localparam int SLOT_W  = 5;
    localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [31:0] TYPE_KEEP = 32'((64'd1 << NUM_TYPES) - 64'd1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;

    localparam logic [2:0] KIND_ADDED   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_REMOVED = 3'd2;
    localparam logic [2:0] KIND_NOTICE  = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_SCAN,
        ST_END
    } state_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [4:0]         ctype;
        logic [31:0]        mask;
        logic               notify;
    } entry_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] rx;
        logic [SLOT_W-1:0] ot;
        logic              last;
    } res_t;

    // strict overlap on one axis, 17-bit sums so nothing wraps
    function automatic logic overlap_1d(
        input logic signed [15:0] a,
        input logic [14:0]        aw,
        input logic signed [15:0] b,
        input logic [14:0]        bw
    );
        logic signed [16:0] a_lo;
        logic signed [16:0] a_hi;
        logic signed [16:0] b_lo;
        logic signed [16:0] b_hi;
        a_lo = {a[15], a};
        b_lo = {b[15], b};
        a_hi = a_lo + $signed({2'b00, aw});
        b_hi = b_lo + $signed({2'b00, bw});
        return (a_lo < b_hi) && (a_hi > b_lo);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/aabb_pair_collision_table_top.sv
// top level of the aabb pair collision table: slot memory, scan sequencer, result buffering
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------------
//  command  | in        | in_valid / in_ready  | op, slot, rect_x/y/w/h, box_type,
//           |           |                      | interest_mask, has_notify
//  result   | out       | out_valid / out_ready| result_kind, receiver_slot, other_slot, last
//
//  add, remove and a scan that finds nothing to scan are answered straight from idle
//  a scan of slot i reads the base entry, then each later slot in turn through the single read port
//  of the entry memory, one later slot read per cycle unless the result side stalls or a pair
//  notifies both ways, which holds the read for the second notice
//  reset clears the valid bits, so the table is empty at once; entry memory is not cleared
//  one notice is held back in a pending register so that the final one can carry last
`timescale 1ns / 1ps
`default_nettype none

module aabb_pair_collision_table_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  op,
    input  wire logic [apct_pkg::SLOT_W-1:0] slot,
    input  wire logic signed [15:0]          rect_x,
    input  wire logic signed [15:0]          rect_y,
    input  wire logic [14:0]                 rect_w,
    input  wire logic [14:0]                 rect_h,
    input  wire logic [4:0]                  box_type,
    input  wire logic [31:0]                 interest_mask,
    input  wire logic                        has_notify,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [2:0]                       result_kind,
    output logic [apct_pkg::SLOT_W-1:0]      receiver_slot,
    output logic [apct_pkg::SLOT_W-1:0]      other_slot,
    output logic                             last
);
    import apct_pkg::*;

    // entry memory, one read port with registered data, one write port
    entry_t mem [NUM_SLOTS];
    entry_t rd_data_reg;
    logic               rd_en;
    logic [SLOT_IW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_IW-1:0] wr_addr;
    entry_t             wr_data;

    // control state
    state_t             state_reg, state_next;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic               valid_set, valid_clr;
    logic [SLOT_IW-1:0] valid_set_idx, valid_clr_idx;
    logic               phase_reg, phase_next;
    logic               pend_vld_reg, pend_vld_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    entry_t             base_reg;
    logic [SLOT_IW-1:0] base_slot_reg, base_slot_next;
    logic [SLOT_IW-1:0] cmp_k_reg, cmp_k_next;
    res_t               pend_reg, pend_next;
    res_t               out_reg, out_next;
    logic               pend_load, out_load;

    // lowest free slot
    logic               free_found;
    logic [SLOT_IW-1:0] free_idx;

    // compare of the base entry against the entry just read
    logic               ovl;
    logic               hit_a, hit_b;
    logic               need_emit, can_push, can_emit;
    res_t               emit_res;

    logic               slot_in_range;
    logic [SLOT_IW-1:0] slot_idx;
    logic               accept;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_IW'(s);
            end
        end
    end

    assign slot_in_range = ({1'b0, slot} < (SLOT_W + 1)'(NUM_SLOTS));
    assign slot_idx      = slot[SLOT_IW-1:0];

    assign ovl   = overlap_1d(base_reg.x, base_reg.w, rd_data_reg.x, rd_data_reg.w) &&
                   overlap_1d(base_reg.y, base_reg.h, rd_data_reg.y, rd_data_reg.h);
    assign hit_a = valid_reg[cmp_k_reg] && ovl && base_reg.notify &&
                   base_reg.mask[rd_data_reg.ctype];
    assign hit_b = valid_reg[cmp_k_reg] && ovl && rd_data_reg.notify &&
                   rd_data_reg.mask[base_reg.ctype];

    assign can_push = !out_valid_reg || out_ready;
    assign can_emit = !pend_vld_reg || can_push;
    assign in_ready = (state_reg == ST_IDLE) && can_push;
    assign accept   = in_valid && in_ready;

    // notice to the base slot first, then the reverse one
    always_comb
    begin
        need_emit = phase_reg || hit_a || hit_b;
        if (phase_reg || !hit_a)
        begin
            emit_res = '{kind: KIND_NOTICE, rx: SLOT_W'(cmp_k_reg),
                         ot: SLOT_W'(base_slot_reg), last: 1'b0};
        end
        else
        begin
            emit_res = '{kind: KIND_NOTICE, rx: SLOT_W'(base_slot_reg),
                         ot: SLOT_W'(cmp_k_reg), last: 1'b0};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        pend_load      = 1'b0;
        out_load       = 1'b0;
        out_next       = out_reg;
        base_slot_next = base_slot_reg;
        cmp_k_next     = cmp_k_reg;
        rd_en          = 1'b0;
        rd_addr        = cmp_k_reg;
        wr_en          = 1'b0;
        wr_addr        = free_idx;
        wr_data        = '{x: rect_x, y: rect_y, w: rect_w, h: rect_h, ctype: box_type,
                           mask: interest_mask & TYPE_KEEP, notify: has_notify};
        valid_set      = 1'b0;
        valid_set_idx  = free_idx;
        valid_clr      = 1'b0;
        valid_clr_idx  = slot_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ADD:
                        begin
                            out_load = 1'b1;
                            if (free_found)
                            begin
                                wr_en     = 1'b1;
                                valid_set = 1'b1;
                                out_next  = '{kind: KIND_ADDED, rx: SLOT_W'(free_idx),
                                              ot: '0, last: 1'b1};
                            end
                            else
                            begin
                                out_next = '{kind: KIND_FULL, rx: '0, ot: '0, last: 1'b1};
                            end
                        end
                        OP_REMOVE:
                        begin
                            valid_clr = slot_in_range;
                            out_load  = 1'b1;
                            out_next  = '{kind: KIND_REMOVED, rx: slot, ot: '0, last: 1'b1};
                        end
                        OP_SCAN:
                        begin
                            if (slot_in_range && valid_reg[slot_idx])
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = slot_idx;
                                base_slot_next = slot_idx;
                                phase_next     = 1'b0;
                                state_next     = ST_BASE;
                            end
                            else
                            begin
                                out_load = 1'b1;
                                out_next = '{kind: KIND_NONE, rx: slot, ot: '0, last: 1'b1};
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                            out_next = '{kind: KIND_NONE, rx: slot, ot: '0, last: 1'b1};
                        end
                    endcase
                end
            end
            ST_BASE:
            begin
                // base entry lands in base_reg this cycle, first later slot is read unless the base is the last slot
                if (base_slot_reg == SLOT_IW'(NUM_SLOTS - 1))
                begin
                    state_next = ST_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base_slot_reg + SLOT_IW'(1);
                    cmp_k_next = base_slot_reg + SLOT_IW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!need_emit || can_emit)
                begin
                    if (need_emit)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_load = 1'b1;
                            out_next = pend_reg;
                        end
                        pend_load     = 1'b1;
                        pend_next     = emit_res;
                        pend_vld_next = 1'b1;
                    end
                    if (!phase_reg && hit_a && hit_b)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (cmp_k_reg == SLOT_IW'(NUM_SLOTS - 1))
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cmp_k_reg + SLOT_IW'(1);
                            cmp_k_next = cmp_k_reg + SLOT_IW'(1);
                        end
                    end
                end
            end
            ST_END:
            begin
                if (can_push)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (pend_vld_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                        pend_vld_next = 1'b0;
                    end
                    else
                    begin
                        out_next = '{kind: KIND_NONE, rx: SLOT_W'(base_slot_reg),
                                     ot: '0, last: 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            phase_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            if (valid_set)
            begin
                valid_reg[valid_set_idx] <= 1'b1;
            end
            if (valid_clr)
            begin
                valid_reg[valid_clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_slot_reg <= base_slot_next;
        cmp_k_reg     <= cmp_k_next;
        if (state_reg == ST_BASE)
        begin
            base_reg <= rd_data_reg;
        end
        if (pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.kind;
    assign receiver_slot = out_reg.rx;
    assign other_slot    = out_reg.ot;
    assign last          = out_reg.last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for the aabb pair collision table: directed rows, then random traffic checked against a shadow table
`timescale 1ns / 1ps

module testbench;
    import apct_pkg::*;

    // op code 3 has no name in the package; the block answers it like an empty scan
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int HOLD_CYCLES      = 600;
    localparam int RANDOM_PER_PHASE = 15;
    localparam int DRAIN_CYCLES     = NUM_SLOTS + 8;
    localparam int REPORT_MAX       = 10;

    // per-phase idle percentages: sender gaps and receiver stalls
    localparam int PHASE_IDLE  [4] = '{0, 81, 0, 8};
    localparam int PHASE_STALL [4] = '{0, 0, 81, 8};

    // one command transaction, field for field as it sits on the ports
    typedef struct packed {
        logic [1:0]         op;
        logic [4:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [4:0]         ctype;
        logic [31:0]        mask;
        logic               notify;
    } cmd_t;

    // directed row: the command plus, where it is obvious, its single answer
    typedef struct {
        cmd_t       cmd;
        bit         typed;
        logic [2:0] kind;
        logic [4:0] rx;
    } row_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [1:0]          op            = '0;
    logic [SLOT_W-1:0]   slot          = '0;
    logic signed [15:0]  rect_x        = '0;
    logic signed [15:0]  rect_y        = '0;
    logic [14:0]         rect_w        = '0;
    logic [14:0]         rect_h        = '0;
    logic [4:0]          box_type      = '0;
    logic [31:0]         interest_mask = '0;
    logic                has_notify    = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [2:0]          result_kind;
    logic [SLOT_W-1:0]   receiver_slot;
    logic [SLOT_W-1:0]   other_slot;
    logic                last;

    // shadow of the slot table and the answers still owed by the block
    bit     shadow_valid [NUM_SLOTS];
    entry_t shadow_ent   [NUM_SLOTS];
    res_t   step_outcomes [$];
    res_t   outcome_q     [$];

    // traffic shaping, set by the stimulus process; hold_elapsed is counted by the receiver
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_armed   = 1'b0;
    int   hold_elapsed = 0;

    int cycle_count     = 0;
    int error_count     = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int notices_seen    = 0;
    int full_seen       = 0;

    // directed part: empty table, field extremes, touching edges, a zero-size box,
    // one-way notices, slot reuse after remove and the unused op code
    row_t directed_rows [17] = '{
        // empty table: scan, remove of a free slot, unused op code
        '{'{OP_SCAN,   5'd0,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0,  32'h0000_0000, 1'b0},
          1'b1, KIND_NONE, 5'd0},
        '{'{OP_REMOVE, 5'd31, 16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0,  32'h0000_0000, 1'b0},
          1'b1, KIND_REMOVED, 5'd31},
        '{'{OP_UNUSED, 5'd7,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0,  32'h0000_0000, 1'b0},
          1'b1, KIND_NONE, 5'd7},
        // most negative corner, largest size
        '{'{OP_ADD,    5'd31, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 5'd0, 32'hffff_ffff, 1'b1},
          1'b1, KIND_ADDED, 5'd0},
        // most positive corner, largest size, highest type code
        '{'{OP_ADD,    5'd0,  16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 5'd31, 32'hffff_ffff, 1'b1},
          1'b1, KIND_ADDED, 5'd1},
        // touches the first box above exactly at an edge and stops short of the second, so no overlap
        '{'{OP_ADD,    5'd0,  16'shffff, 16'shffff, 15'h7fff, 15'h7fff, 5'd5, 32'h0000_0001, 1'b1},
          1'b1, KIND_ADDED, 5'd2},
        // zero-size box strictly inside the previous one
        '{'{OP_ADD,    5'd0,  16'sh0064, 16'sh0064, 15'd0, 15'd0, 5'd31, 32'h8000_0020, 1'b1},
          1'b1, KIND_ADDED, 5'd3},
        // big box without a receiver
        '{'{OP_ADD,    5'd0,  16'shff9c, 16'shff9c, 15'h7fff, 15'h7fff, 5'd0, 32'hffff_ffff, 1'b0},
          1'b1, KIND_ADDED, 5'd4},
        '{'{OP_SCAN,   5'd0,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b0, KIND_NONE, 5'd0},
        '{'{OP_SCAN,   5'd2,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b0, KIND_NONE, 5'd0},
        '{'{OP_SCAN,   5'd1,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b0, KIND_NONE, 5'd0},
        '{'{OP_SCAN,   5'd3,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b0, KIND_NONE, 5'd0},
        // free a slot, scan it, then the next add must land there
        '{'{OP_REMOVE, 5'd1,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b1, KIND_REMOVED, 5'd1},
        '{'{OP_SCAN,   5'd1,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b1, KIND_NONE, 5'd1},
        '{'{OP_ADD,    5'd9,  16'sh0000, 16'sh0000, 15'd5, 15'd5, 5'd16, 32'haaaa_5555, 1'b0},
          1'b1, KIND_ADDED, 5'd1},
        '{'{OP_SCAN,   5'd0,  16'sh0000, 16'sh0000, 15'd0, 15'd0, 5'd0, 32'h0, 1'b0},
          1'b0, KIND_NONE, 5'd0},
        '{'{OP_UNUSED, 5'd31, 16'sh7fff, 16'sh8000, 15'h7fff, 15'd0, 5'd31, 32'hffff_ffff, 1'b1},
          1'b1, KIND_NONE, 5'd31}
    };

    aabb_pair_collision_table_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .slot          (slot),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_w        (rect_w),
        .rect_h        (rect_h),
        .box_type      (box_type),
        .interest_mask (interest_mask),
        .has_notify    (has_notify),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .receiver_slot (receiver_slot),
        .other_slot    (other_slot),
        .last          (last)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // does entry who want a notice about entry other
    function automatic bit wants_notice(input int who, input int other);
        return shadow_ent[who].notify && shadow_ent[who].mask[shadow_ent[other].ctype];
    endfunction

    // applies one command to the shadow table and leaves its answers in step_outcomes
    function automatic void apply_table_op(input cmd_t c);
        int free_slot;
        int i;
        int ax, ay, aw, ah;
        int bx, by, bw, bh;
        step_outcomes.delete();
        i = int'(c.slot);
        case (c.op)
            OP_ADD:
            begin
                // lowest free slot wins
                free_slot = -1;
                for (int s = NUM_SLOTS - 1; s >= 0; s--)
                    if (!shadow_valid[s])
                        free_slot = s;
                if (free_slot >= 0)
                begin
                    shadow_valid[free_slot] = 1'b1;
                    shadow_ent[free_slot]   = '{c.x, c.y, c.w, c.h, c.ctype,
                                                c.mask & TYPE_KEEP, c.notify};
                    step_outcomes.push_back('{KIND_ADDED, SLOT_W'(free_slot), '0, 1'b0});
                end
                else
                    step_outcomes.push_back('{KIND_FULL, '0, '0, 1'b0});
            end
            OP_REMOVE:
            begin
                if (i < NUM_SLOTS)
                    shadow_valid[i] = 1'b0;
                step_outcomes.push_back('{KIND_REMOVED, c.slot, '0, 1'b0});
            end
            OP_SCAN:
            begin
                if (i < NUM_SLOTS && shadow_valid[i])
                begin
                    // sign- and zero-extend to 32 bits so edge sums never wrap
                    ax = {{16{shadow_ent[i].x[15]}}, shadow_ent[i].x};
                    ay = {{16{shadow_ent[i].y[15]}}, shadow_ent[i].y};
                    aw = int'(shadow_ent[i].w);
                    ah = int'(shadow_ent[i].h);
                    for (int k = i + 1; k < NUM_SLOTS; k++)
                    begin
                        if (!shadow_valid[k])
                            continue;
                        bx = {{16{shadow_ent[k].x[15]}}, shadow_ent[k].x};
                        by = {{16{shadow_ent[k].y[15]}}, shadow_ent[k].y};
                        bw = int'(shadow_ent[k].w);
                        bh = int'(shadow_ent[k].h);
                        // strict overlap: touching edges do not count
                        if (!(ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by))
                            continue;
                        if (wants_notice(i, k))
                            step_outcomes.push_back('{KIND_NOTICE, SLOT_W'(i), SLOT_W'(k), 1'b0});
                        if (wants_notice(k, i))
                            step_outcomes.push_back('{KIND_NOTICE, SLOT_W'(k), SLOT_W'(i), 1'b0});
                    end
                end
            end
            default:
            begin
            end
        endcase
        // free slot scans, quiet scans and the unused op all answer the same way
        if (step_outcomes.size() == 0)
            step_outcomes.push_back('{KIND_NONE, c.slot, '0, 1'b0});
        step_outcomes[step_outcomes.size() - 1].last = 1'b1;
    endfunction

    // random command shaped by the current table occupancy
    function automatic cmd_t random_command();
        cmd_t c;
        int   live [$];
        int   r;
        c.op     = OP_ADD;
        c.slot   = 5'($urandom);
        c.x      = 16'($urandom);
        c.y      = 16'($urandom);
        c.w      = 15'($urandom);
        c.h      = 15'($urandom);
        c.ctype  = 5'($urandom);
        c.mask   = $urandom();
        c.notify = 1'($urandom);
        foreach (shadow_valid[s])
            if (shadow_valid[s])
                live.push_back(s);
        r = $urandom_range(99);
        // a crowded table leans toward removes so adds keep landing
        if (live.size() > 24)
            c.op = (r < 25) ? OP_ADD : (r < 55) ? OP_REMOVE : (r < 96) ? OP_SCAN : OP_UNUSED;
        else
            c.op = (r < 45) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 96) ? OP_SCAN : OP_UNUSED;
        // most boxes are small and clustered so scans find overlaps
        if (c.op == OP_ADD && $urandom_range(99) < 85)
        begin
            c.x      = 16'(int'($urandom_range(511)) - 256);
            c.y      = 16'(int'($urandom_range(511)) - 256);
            c.w      = 15'($urandom_range(300));
            c.h      = 15'($urandom_range(300));
            c.notify = ($urandom_range(9) != 0);
        end
        // removes and scans mostly hit live slots
        if ((c.op == OP_REMOVE || c.op == OP_SCAN) && live.size() > 0
            && $urandom_range(99) < 85)
            c.slot = 5'(live[$urandom_range(live.size() - 1)]);
        return c;
    endfunction

    // drives one command transaction and books its answers once it is accepted
    task automatic offer_command(input cmd_t c, input bit typed, input res_t typed_res);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= c.op;
        slot          <= c.slot;
        rect_x        <= c.x;
        rect_y        <= c.y;
        rect_w        <= c.w;
        rect_h        <= c.h;
        box_type      <= c.ctype;
        interest_mask <= c.mask;
        has_notify    <= c.notify;
        // handshake is judged mid-cycle, where both sides are settled
        while (!taken)
        begin
            @(negedge clk);
            if (in_ready)
            begin
                taken = 1'b1;
                apply_table_op(c);
                if (typed)
                    outcome_q.push_back(typed_res);
                else
                    foreach (step_outcomes[j])
                        outcome_q.push_back(step_outcomes[j]);
                commands_sent++;
            end
            @(posedge clk);
        end
    endtask

    // clear the table, refill it with mutually overlapping boxes until it reports full,
    // then scan; the result side is held off meanwhile so the block backs up
    task automatic refill_overlapping();
        int   live [$];
        int   scan_slots [4];
        cmd_t c;
        scan_slots = '{0, 1, NUM_SLOTS / 2, NUM_SLOTS - 1};
        foreach (shadow_valid[s])
            if (shadow_valid[s])
                live.push_back(s);
        hold_armed <= 1'b1;
        foreach (live[n])
        begin
            c      = random_command();
            c.op   = OP_REMOVE;
            c.slot = 5'(live[n]);
            offer_command(c, 1'b0, '0);
        end
        // every box contains the unit square at the origin, so all pairs overlap
        repeat (NUM_SLOTS + 2)
        begin
            c    = random_command();
            c.op = OP_ADD;
            c.x  = 16'(int'($urandom_range(64)) - 64);
            c.y  = 16'(int'($urandom_range(64)) - 64);
            c.w  = 15'($urandom_range(400, 65));
            c.h  = 15'($urandom_range(400, 65));
            if ($urandom_range(3) != 0)
                c.mask = '1;
            c.notify = ($urandom_range(9) != 0);
            offer_command(c, 1'b0, '0);
        end
        foreach (scan_slots[n])
        begin
            c      = random_command();
            c.op   = OP_SCAN;
            c.slot = 5'(scan_slots[n]);
            offer_command(c, 1'b0, '0);
        end
    endtask

    function automatic void flag_error(input string what);
        if (error_count < REPORT_MAX)
            $display("result error at cycle %0d: %s", cycle_count, what);
        error_count++;
    endfunction

    // receiver: one long hold-off when armed, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_armed && hold_elapsed < HOLD_CYCLES)
        begin
            hold_elapsed <= hold_elapsed + 1;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker: each accepted result against the oldest owed answer
    always @(negedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (result_kind == KIND_NOTICE)
                notices_seen++;
            if (result_kind == KIND_FULL)
                full_seen++;
            if (outcome_q.size() == 0)
                flag_error($sformatf("unexpected result kind %0d rx %0d ot %0d last %0d",
                                     result_kind, receiver_slot, other_slot, last));
            else
            begin
                want = outcome_q.pop_front();
                if (result_kind !== want.kind || receiver_slot !== want.rx
                    || other_slot !== want.ot || last !== want.last)
                    flag_error($sformatf(
                        "expected kind %0d rx %0d ot %0d last %0d, got kind %0d rx %0d ot %0d last %0d",
                        want.kind, want.rx, want.ot, want.last,
                        result_kind, receiver_slot, other_slot, last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, outcome_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus: reset, directed rows, refill under pressure, then four random phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_command(directed_rows[i].cmd, directed_rows[i].typed,
                          '{directed_rows[i].kind, directed_rows[i].rx, '0, 1'b1});

        refill_overlapping();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct   = PHASE_IDLE[p];
            stall_pct <= PHASE_STALL[p];
            repeat (RANDOM_PER_PHASE)
                offer_command(random_command(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // wait for every owed answer, then give stray results time to show up
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d commands over directed rows, a full-table refill behind a long",
                 commands_sent);
        $display("result hold-off and four idle mixes; %0d results, %0d notices, %0d full, %0d errors",
                 results_checked, notices_seen, full_seen, error_count);
        if (error_count == 0 && outcome_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
